@@ rtl/bnbw_pkg.sv @@
`timescale 1ns / 1ps

package bnbw_pkg;

  localparam int ACC_WIDTH_DEF    = 48;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int SCALE_W  = 16;
  localparam int MEAN_W   = 16;
  localparam int ISTD_W   = 16;
  localparam int ICNT_W   = 24;
  localparam int ECNT_W   = 21;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd4096;
  localparam logic [MEAN_W-1:0]  MEAN_RST  = 16'd0;
  localparam logic [ISTD_W-1:0]  ISTD_RST  = 16'd256;
  localparam logic [ICNT_W-1:0]  ICNT_RST  = 24'hFFFFFF;
  localparam logic [ECNT_W-1:0]  ECNT_RST  = 21'd1;

  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SUM_W      = 65;
  localparam int WIDE_W     = 128;
  localparam int XHAT_W     = 32;
  localparam int COEF_W     = 56;
  localparam int BR_W       = 64;
  localparam int XHAT_SHIFT = 8;
  localparam int T_SHIFT    = 24;
  localparam int DX_SHIFT   = 44;

  typedef enum logic [2:0] {
    REG_SCALE = 3'd0,
    REG_MEAN  = 3'd1,
    REG_ISTD  = 3'd2,
    REG_ICNT  = 3'd3,
    REG_ECNT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MS_NONE = 4'd0,
    MS_XH   = 4'd1,
    MS_XDY  = 4'd2,
    MS_XLO  = 4'd3,
    MS_XHI  = 4'd4,
    MS_ECDY = 4'd5,
    MS_SV   = 4'd6,
    MS_CF   = 4'd7,
    MS_CLBL = 4'd8,
    MS_CLBH = 4'd9,
    MS_CHBL = 4'd10,
    MS_CHBH = 4'd11
  } mul_sel_t;

  typedef enum logic [1:0] {
    W_HOLD  = 2'd0,
    W_LOAD  = 2'd1,
    W_ADD32 = 2'd2,
    W_ADD64 = 2'd3
  } w_op_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    w_op_t    w_op;
    logic     xhat_en;
    logic     acc_en;
    logic     tbr_en;
    logic     br2_en;
    logic     coef_en;
    logic     emit_sums;
    logic     emit_dx;
  } dp_cmd_t;

  typedef struct packed {
    logic req_type;
    logic last;
  } dp_sts_t;

endpackage

@@ rtl/batchnorm_backward_channel_unit.sv @@
`timescale 1ns / 1ps

// Batch-norm backward for one channel. An item is taken when start is high and busy
// is low; busy stays high until the item is done. An accumulate item (req type 0)
// emits a result only on the item marked last, and that result carries both channel
// sums. A gradient item (req type 1) always emits dx. Every product, including the
// split wide products, comes from one shared 33x33 multiplier, one at a time. Each
// result is on the out_ ports for one cycle with out_valid high, in the first cycle
// that busy is low again; the receiver cannot stall, so it must take every strobe.
// Write configuration only while busy is low and no result is pending.
module batchnorm_backward_channel_unit #(
  parameter int ACC_WIDTH    = bnbw_pkg::ACC_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = bnbw_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_x_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_dy_sample,
  input  logic                             in_last,
  input  logic                             cfg_we,
  input  logic [bnbw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bnbw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  output logic                             out_kind,
  output logic signed [SAMPLE_WIDTH-1:0]   out_dx,
  output logic signed [ACC_WIDTH-1:0]      out_grad_bias,
  output logic signed [ACC_WIDTH-1:0]      out_grad_scale
);

  bnbw_pkg::dp_cmd_t cmd;
  bnbw_pkg::dp_sts_t sts;

  bnbw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bnbw_dp #(
    .ACC_WIDTH    (ACC_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_x_sample    (in_x_sample),
    .in_dy_sample   (in_dy_sample),
    .in_last        (in_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_dx         (out_dx),
    .out_grad_bias  (out_grad_bias),
    .out_grad_scale (out_grad_scale)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

  a_dx_on_gradient: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_dx |-> sts.req_type)
    else $error("dx emitted for an accumulate item");

endmodule

@@ rtl/bnbw_ctrl.sv @@
`timescale 1ns / 1ps

module bnbw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bnbw_pkg::dp_sts_t  sts,
  output bnbw_pkg::dp_cmd_t  cmd
);

  typedef enum logic [16:0] {
    ST_IDLE    = 17'b00000000000000001,
    ST_XH_MUL  = 17'b00000000000000010,
    ST_XH_RND  = 17'b00000000000000100,
    ST_XDY_MUL = 17'b00000000000001000,
    ST_ACC     = 17'b00000000000010000,
    ST_T_LO    = 17'b00000000000100000,
    ST_T_HI    = 17'b00000000001000000,
    ST_T_SUM   = 17'b00000000010000000,
    ST_TBR     = 17'b00000000100000000,
    ST_COEF    = 17'b00000001000000000,
    ST_COEF_LD = 17'b00000010000000000,
    ST_D_LL    = 17'b00000100000000000,
    ST_D_LH    = 17'b00001000000000000,
    ST_D_HL    = 17'b00010000000000000,
    ST_D_HH    = 17'b00100000000000000,
    ST_D_SUM   = 17'b01000000000000000,
    ST_DX      = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = ST_XH_MUL;
        end
      end
      ST_XH_MUL: begin
        cmd.mul_sel = bnbw_pkg::MS_XH;
        state_nxt   = ST_XH_RND;
      end
      ST_XH_RND: begin
        cmd.xhat_en = 1'b1;
        state_nxt   = sts.req_type ? ST_T_LO : ST_XDY_MUL;
      end
      ST_XDY_MUL: begin
        cmd.mul_sel = bnbw_pkg::MS_XDY;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en    = 1'b1;
        cmd.emit_sums = sts.last;
        state_nxt     = ST_IDLE;
      end
      ST_T_LO: begin
        cmd.mul_sel = bnbw_pkg::MS_XLO;
        state_nxt   = ST_T_HI;
      end
      ST_T_HI: begin
        cmd.mul_sel = bnbw_pkg::MS_XHI;
        cmd.w_op    = bnbw_pkg::W_LOAD;
        state_nxt   = ST_T_SUM;
      end
      ST_T_SUM: begin
        cmd.mul_sel = bnbw_pkg::MS_ECDY;
        cmd.w_op    = bnbw_pkg::W_ADD32;
        state_nxt   = ST_TBR;
      end
      ST_TBR: begin
        cmd.mul_sel = bnbw_pkg::MS_SV;
        cmd.tbr_en  = 1'b1;
        state_nxt   = ST_COEF;
      end
      ST_COEF: begin
        cmd.mul_sel = bnbw_pkg::MS_CF;
        cmd.br2_en  = 1'b1;
        state_nxt   = ST_COEF_LD;
      end
      ST_COEF_LD: begin
        cmd.coef_en = 1'b1;
        state_nxt   = ST_D_LL;
      end
      ST_D_LL: begin
        cmd.mul_sel = bnbw_pkg::MS_CLBL;
        state_nxt   = ST_D_LH;
      end
      ST_D_LH: begin
        cmd.mul_sel = bnbw_pkg::MS_CLBH;
        cmd.w_op    = bnbw_pkg::W_LOAD;
        state_nxt   = ST_D_HL;
      end
      ST_D_HL: begin
        cmd.mul_sel = bnbw_pkg::MS_CHBL;
        cmd.w_op    = bnbw_pkg::W_ADD32;
        state_nxt   = ST_D_HH;
      end
      ST_D_HH: begin
        cmd.mul_sel = bnbw_pkg::MS_CHBH;
        cmd.w_op    = bnbw_pkg::W_ADD32;
        state_nxt   = ST_D_SUM;
      end
      ST_D_SUM: begin
        cmd.w_op  = bnbw_pkg::W_ADD64;
        state_nxt = ST_DX;
      end
      ST_DX: begin
        cmd.emit_dx = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bnbw_dp.sv @@
`timescale 1ns / 1ps

module bnbw_dp #(
  parameter int ACC_WIDTH    = bnbw_pkg::ACC_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = bnbw_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bnbw_pkg::dp_cmd_t                   cmd,
  output bnbw_pkg::dp_sts_t                   sts,
  input  logic                                in_req_type,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_x_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_dy_sample,
  input  logic                                in_last,
  input  logic                                cfg_we,
  input  logic [bnbw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bnbw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  output logic                                out_kind,
  output logic signed [SAMPLE_WIDTH-1:0]      out_dx,
  output logic signed [ACC_WIDTH-1:0]         out_grad_bias,
  output logic signed [ACC_WIDTH-1:0]         out_grad_scale
);

  localparam int AW     = ACC_WIDTH;
  localparam int SW     = SAMPLE_WIDTH;
  localparam int MW     = bnbw_pkg::MUL_W;
  localparam int PW     = bnbw_pkg::PROD_W;
  localparam int UW     = bnbw_pkg::SUM_W;
  localparam int WW     = bnbw_pkg::WIDE_W;
  localparam int XW     = bnbw_pkg::XHAT_W;
  localparam int CW     = bnbw_pkg::COEF_W;
  localparam int BW     = bnbw_pkg::BR_W;

  localparam logic signed [UW-1:0] ACC_HI = (UW'(1) <<< (AW - 1)) - UW'(1);
  localparam logic signed [UW-1:0] ACC_LO = -ACC_HI - 1;
  localparam logic signed [PW-1:0] XH_HI  = (PW'(1) <<< (XW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] XH_LO  = -XH_HI - 1;
  localparam logic signed [BW-1:0] SW_HI  = (BW'(1) <<< (SW - 1)) - BW'(1);
  localparam logic signed [BW-1:0] SW_LO  = -SW_HI - 1;
  localparam logic signed [BW-1:0] B_MAX  = {1'b0, {(BW-1){1'b1}}};
  localparam logic signed [BW-1:0] B_MIN  = {1'b1, {(BW-1){1'b0}}};
  localparam logic signed [PW-1:0] XH_HALF = PW'(1) <<< (bnbw_pkg::XHAT_SHIFT - 1);

  function automatic logic signed [AW-1:0] clamp_acc(input logic signed [UW-1:0] v);
    if (v > ACC_HI) return ACC_HI[AW-1:0];
    else if (v < ACC_LO) return ACC_LO[AW-1:0];
    else return v[AW-1:0];
  endfunction

  function automatic logic signed [BW-1:0] clamp_b(input logic signed [UW-1:0] v);
    if (v[UW-1] != v[UW-2]) return v[UW-1] ? B_MIN : B_MAX;
    else return v[BW-1:0];
  endfunction

  function automatic logic signed [XW-1:0] clamp_xhat(input logic signed [PW-1:0] v);
    if (v > XH_HI) return XH_HI[XW-1:0];
    else if (v < XH_LO) return XH_LO[XW-1:0];
    else return v[XW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] clamp_sw(input logic signed [BW-1:0] v);
    if (v > SW_HI) return SW_HI[SW-1:0];
    else if (v < SW_LO) return SW_LO[SW-1:0];
    else return v[SW-1:0];
  endfunction

  function automatic logic signed [BW-1:0] rnd_sat(input logic signed [WW-1:0] w,
                                                   input int unsigned s);
    logic signed [WW-1:0] sum;
    logic signed [WW-1:0] sh;
    sum = w + (WW'(1) <<< (s - 1));
    sh  = sum >>> s;
    if (sh[WW-1:BW-1] != {(WW-BW+1){sh[BW-1]}}) return sum[WW-1] ? B_MIN : B_MAX;
    else return sh[BW-1:0];
  endfunction

  // configuration
  logic signed [bnbw_pkg::SCALE_W-1:0] scale_r;
  logic signed [bnbw_pkg::MEAN_W-1:0]  mean_r;
  logic [bnbw_pkg::ISTD_W-1:0]         istd_r;
  logic [bnbw_pkg::ICNT_W-1:0]         icnt_r;
  logic [bnbw_pkg::ECNT_W-1:0]         ecnt_r;

  // item and working registers
  logic                  req_r;
  logic                  last_r;
  logic signed [SW-1:0]  xs_r;
  logic signed [SW-1:0]  dy_r;
  logic signed [XW-1:0]  xhat_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [WW-1:0]  w_r, w_nxt;
  logic signed [BW-1:0]  t_r;
  logic signed [BW-1:0]  br_r;
  logic signed [CW-1:0]  coef_r;

  // channel state
  logic                  pass_open_r;
  logic signed [AW-1:0]  acc_dy_r, acc_dy_nxt;
  logic signed [AW-1:0]  acc_xd_r, acc_xd_nxt;
  logic signed [AW-1:0]  held_dy_r;
  logic signed [AW-1:0]  held_xd_r;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [MW-1:0]  xs33, dy33, xhat33, coef_hi33, br_hi33;
  logic signed [WW-1:0]  prod_ext;
  logic signed [AW-1:0]  base_dy, base_xd;
  logic signed [PW-1:0]  xh_rnd;

  assign sts.req_type = req_r;
  assign sts.last     = last_r;

  assign xs33      = {{(MW-SW){xs_r[SW-1]}}, xs_r};
  assign dy33      = {{(MW-SW){dy_r[SW-1]}}, dy_r};
  assign xhat33    = {{(MW-XW){xhat_r[XW-1]}}, xhat_r};
  assign coef_hi33 = {{(MW-(CW-32)){coef_r[CW-1]}}, coef_r[CW-1:32]};
  assign br_hi33   = {{(MW-(BW-32)){br_r[BW-1]}}, br_r[BW-1:32]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      bnbw_pkg::MS_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      bnbw_pkg::MS_XH: begin
        mul_a = xs33 - {{(MW-bnbw_pkg::MEAN_W){mean_r[bnbw_pkg::MEAN_W-1]}}, mean_r};
        mul_b = {{(MW-bnbw_pkg::ISTD_W){1'b0}}, istd_r};
      end
      bnbw_pkg::MS_XDY: begin
        mul_a = xhat33;
        mul_b = dy33;
      end
      bnbw_pkg::MS_XLO: begin
        mul_a = xhat33;
        mul_b = {1'b0, held_xd_r[31:0]};
      end
      bnbw_pkg::MS_XHI: begin
        mul_a = xhat33;
        mul_b = {{(MW-(AW-32)){held_xd_r[AW-1]}}, held_xd_r[AW-1:32]};
      end
      bnbw_pkg::MS_ECDY: begin
        mul_a = {{(MW-bnbw_pkg::ECNT_W){1'b0}}, ecnt_r};
        mul_b = dy33;
      end
      bnbw_pkg::MS_SV: begin
        mul_a = {{(MW-bnbw_pkg::SCALE_W){scale_r[bnbw_pkg::SCALE_W-1]}}, scale_r};
        mul_b = {{(MW-bnbw_pkg::ISTD_W){1'b0}}, istd_r};
      end
      bnbw_pkg::MS_CF: begin
        mul_a = prod_r[MW-1:0];
        mul_b = {{(MW-bnbw_pkg::ICNT_W){1'b0}}, icnt_r};
      end
      bnbw_pkg::MS_CLBL: begin
        mul_a = {1'b0, coef_r[31:0]};
        mul_b = {1'b0, br_r[31:0]};
      end
      bnbw_pkg::MS_CLBH: begin
        mul_a = {1'b0, coef_r[31:0]};
        mul_b = br_hi33;
      end
      bnbw_pkg::MS_CHBL: begin
        mul_a = coef_hi33;
        mul_b = {1'b0, br_r[31:0]};
      end
      bnbw_pkg::MS_CHBH: begin
        mul_a = coef_hi33;
        mul_b = br_hi33;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(WW-PW){prod_r[PW-1]}}, prod_r};
  assign xh_rnd   = (prod_r + XH_HALF) >>> bnbw_pkg::XHAT_SHIFT;

  always_comb begin
    case (cmd.w_op)
      bnbw_pkg::W_LOAD:  w_nxt = prod_ext;
      bnbw_pkg::W_ADD32: w_nxt = w_r + (prod_ext <<< 32);
      bnbw_pkg::W_ADD64: w_nxt = w_r + (prod_ext <<< 64);
      default:           w_nxt = w_r;
    endcase
  end

  // a pass that is not yet open starts from zero
  assign base_dy    = pass_open_r ? acc_dy_r : '0;
  assign base_xd    = pass_open_r ? acc_xd_r : '0;
  assign acc_dy_nxt = clamp_acc({{(UW-AW){base_dy[AW-1]}}, base_dy}
                                + {{(UW-SW){dy_r[SW-1]}}, dy_r});
  assign acc_xd_nxt = clamp_acc({{(UW-AW){base_xd[AW-1]}}, base_xd} + prod_r[UW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= bnbw_pkg::SCALE_RST;
      mean_r      <= bnbw_pkg::MEAN_RST;
      istd_r      <= bnbw_pkg::ISTD_RST;
      icnt_r      <= bnbw_pkg::ICNT_RST;
      ecnt_r      <= bnbw_pkg::ECNT_RST;
      pass_open_r <= 1'b0;
      acc_dy_r    <= '0;
      acc_xd_r    <= '0;
      held_dy_r   <= '0;
      held_xd_r   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bnbw_pkg::REG_SCALE: scale_r <= cfg_data[bnbw_pkg::SCALE_W-1:0];
          bnbw_pkg::REG_MEAN:  mean_r  <= cfg_data[bnbw_pkg::MEAN_W-1:0];
          bnbw_pkg::REG_ISTD:  istd_r  <= cfg_data[bnbw_pkg::ISTD_W-1:0];
          bnbw_pkg::REG_ICNT:  icnt_r  <= cfg_data[bnbw_pkg::ICNT_W-1:0];
          bnbw_pkg::REG_ECNT:  ecnt_r  <= cfg_data[bnbw_pkg::ECNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.acc_en) begin
        acc_dy_r    <= acc_dy_nxt;
        acc_xd_r    <= acc_xd_nxt;
        pass_open_r <= !last_r;
        if (last_r) begin
          held_dy_r <= acc_dy_nxt;
          held_xd_r <= acc_xd_nxt;
        end
      end
      out_valid <= cmd.emit_sums | cmd.emit_dx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      last_r <= in_last;
      xs_r   <= in_x_sample;
      dy_r   <= in_dy_sample;
    end
    prod_r <= mul_p;
    w_r    <= w_nxt;
    if (cmd.xhat_en) begin
      xhat_r <= clamp_xhat(xh_rnd);
    end
    if (cmd.tbr_en) begin
      t_r  <= rnd_sat(w_r, bnbw_pkg::T_SHIFT);
      br_r <= clamp_b(prod_r[UW-1:0] - {{(UW-AW){held_dy_r[AW-1]}}, held_dy_r});
    end
    if (cmd.br2_en) begin
      br_r <= clamp_b({br_r[BW-1], br_r} - {t_r[BW-1], t_r});
    end
    if (cmd.coef_en) begin
      coef_r <= prod_r[CW-1:0];
    end
    if (cmd.emit_sums) begin
      out_kind       <= 1'b1;
      out_dx         <= '0;
      out_grad_bias  <= acc_dy_nxt;
      out_grad_scale <= acc_xd_nxt;
    end else if (cmd.emit_dx) begin
      out_kind       <= 1'b0;
      out_dx         <= clamp_sw(rnd_sat(w_r, bnbw_pkg::DX_SHIFT));
      out_grad_bias  <= '0;
      out_grad_scale <= '0;
    end
  end

endmodule

@@ verif/batchnorm_backward_channel_unit_tb.sv @@
`timescale 1ns / 1ps

module batchnorm_backward_channel_unit_tb;

  localparam int SW            = bnbw_pkg::SAMPLE_WIDTH_DEF;
  localparam int AW            = bnbw_pkg::ACC_WIDTH_DEF;
  localparam int IDX_W         = bnbw_pkg::CFG_IDX_W;
  localparam int DATA_W        = bnbw_pkg::CFG_DATA_W;
  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int ITEM_TARGET   = 1900;
  localparam int PHASE_ITEMS   = 240;
  localparam int SAT_LEN       = 260;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAX_REPORTS   = 10;
  localparam int CFG_IDX_MAX   = 2 ** IDX_W - 1;
  localparam int DIR_ROWS      = 19;

  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_GRAD  = 1'b1;
  localparam logic KIND_DX   = 1'b0;
  localparam logic KIND_SUMS = 1'b1;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic                 kind;
    logic signed [SW-1:0] dx;
    logic signed [AW-1:0] grad_bias;
    logic signed [AW-1:0] grad_scale;
  } grad_out_t;

  typedef struct packed {
    logic          req;
    logic [SW-1:0] x;
    logic [SW-1:0] dy;
    logic          lst;
    logic          typed;
    grad_out_t     result;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_req_type;
  logic signed [SW-1:0]  in_x_sample;
  logic signed [SW-1:0]  in_dy_sample;
  logic                  in_last;
  logic                  cfg_we;
  logic [IDX_W-1:0]      cfg_index;
  logic [DATA_W-1:0]     cfg_data;
  logic                  out_valid;
  logic                  out_kind;
  logic signed [SW-1:0]  out_dx;
  logic signed [AW-1:0]  out_grad_bias;
  logic signed [AW-1:0]  out_grad_scale;

  // channel registers and pass state as the block should hold them
  logic signed [bnbw_pkg::SCALE_W-1:0] cfg_scale = bnbw_pkg::SCALE_RST;
  logic signed [bnbw_pkg::MEAN_W-1:0]  cfg_mean  = bnbw_pkg::MEAN_RST;
  logic [bnbw_pkg::ISTD_W-1:0]         cfg_istd  = bnbw_pkg::ISTD_RST;
  logic [bnbw_pkg::ICNT_W-1:0]         cfg_icnt  = bnbw_pkg::ICNT_RST;
  logic [bnbw_pkg::ECNT_W-1:0]         cfg_ecnt  = bnbw_pkg::ECNT_RST;
  logic signed [AW-1:0]      acc_dy_sum   = '0;
  logic signed [AW-1:0]      acc_xdy_sum  = '0;
  logic signed [AW-1:0]      held_dy_sum  = '0;
  logic signed [AW-1:0]      held_xdy_sum = '0;
  bit                        pass_open    = 1'b0;

  grad_out_t channel_grads_q[$];

  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  int  total_items  = 0;
  int  acc_items    = 0;
  int  grad_items   = 0;
  int  sums_seen    = 0;
  int  dx_seen      = 0;
  int  settings_run = 1;
  bit  burst_mode   = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_GRAD,  16'h0000, 16'h0000, 1'b0, 1'b1, '{KIND_DX, 16'sd0, 48'sd0, 48'sd0}},
    '{REQ_GRAD,  16'h7FFF, 16'h7FFF, 1'b1, 1'b1, '{KIND_DX, 16'sd32767, 48'sd0, 48'sd0}},
    '{REQ_GRAD,  16'h8000, 16'h8000, 1'b0, 1'b1, '{KIND_DX, 16'sh8000, 48'sd0, 48'sd0}},
    '{REQ_ACCUM, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1,
      '{KIND_SUMS, 16'sd0, 48'sd32767, 48'sd1073676289}},
    '{REQ_ACCUM, 16'h8000, 16'h8000, 1'b1, 1'b1,
      '{KIND_SUMS, 16'sd0, -48'sd32768, 48'sd1073741824}},
    '{REQ_GRAD,  16'h8000, 16'h7FFF, 1'b0, 1'b0, '0},
    '{REQ_GRAD,  16'h7FFF, 16'h8000, 1'b0, 1'b0, '0},
    '{REQ_ACCUM, 16'h1000, 16'h0800, 1'b0, 1'b0, '0},
    '{REQ_ACCUM, 16'hF000, 16'hF800, 1'b0, 1'b0, '0},
    '{REQ_GRAD,  16'h1234, 16'hF000, 1'b0, 1'b0, '0},
    '{REQ_GRAD,  16'h0000, 16'h0001, 1'b1, 1'b0, '0},
    '{REQ_ACCUM, 16'h7FFF, 16'h8000, 1'b0, 1'b0, '0},
    '{REQ_ACCUM, 16'h8000, 16'h7FFF, 1'b0, 1'b0, '0},
    '{REQ_ACCUM, 16'h0001, 16'hFFFF, 1'b1, 1'b0, '0},
    '{REQ_GRAD,  16'h0800, 16'h0400, 1'b0, 1'b0, '0},
    '{REQ_GRAD,  16'hFFFF, 16'h0001, 1'b0, 1'b0, '0},
    '{REQ_ACCUM, 16'h5555, 16'hAAAA, 1'b1, 1'b0, '0},
    '{REQ_GRAD,  16'hAAAA, 16'h5555, 1'b0, 1'b0, '0},
    '{REQ_GRAD,  16'h0000, 16'h0000, 1'b0, 1'b0, '0}
  };

  batchnorm_backward_channel_unit #(
    .ACC_WIDTH   (AW),
    .SAMPLE_WIDTH(SW)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_x_sample   (in_x_sample),
    .in_dy_sample  (in_dy_sample),
    .in_last       (in_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_dx        (out_dx),
    .out_grad_bias (out_grad_bias),
    .out_grad_scale(out_grad_scale)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic wide_t sat_w(input wide_t v, input int w);
    wide_t lim;
    lim = wide_t'(1) <<< (w - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic apply_bwd_sample(input logic req, input logic signed [SW-1:0] x_s,
                                  input logic signed [SW-1:0] dy_s, input logic lst,
                                  output bit has_out, output grad_out_t res);
    wide_t x_w, dy_w, mean_w, scale_w, istd_w, icnt_w, ecnt_w, xhat, t_w, br, coef;
    x_w     = wide_t'(x_s);
    dy_w    = wide_t'(dy_s);
    mean_w  = wide_t'(cfg_mean);
    scale_w = wide_t'(cfg_scale);
    istd_w  = wide_t'(cfg_istd);
    icnt_w  = wide_t'(cfg_icnt);
    ecnt_w  = wide_t'(cfg_ecnt);
    xhat    = sat_w(((x_w - mean_w) * istd_w + 128) >>> bnbw_pkg::XHAT_SHIFT,
                    bnbw_pkg::XHAT_W);
    res     = '0;
    has_out = 1'b0;
    if (req == REQ_ACCUM) begin
      if (!pass_open) begin
        acc_dy_sum  = '0;
        acc_xdy_sum = '0;
        pass_open   = 1'b1;
      end
      acc_dy_sum  = AW'(sat_w(acc_dy_sum + dy_w, AW));
      acc_xdy_sum = AW'(sat_w(acc_xdy_sum + xhat * dy_w, AW));
      if (lst) begin
        held_dy_sum    = acc_dy_sum;
        held_xdy_sum   = acc_xdy_sum;
        pass_open      = 1'b0;
        has_out        = 1'b1;
        res.kind       = KIND_SUMS;
        res.grad_bias  = held_dy_sum;
        res.grad_scale = held_xdy_sum;
      end
    end else begin
      t_w  = sat_w((xhat * held_xdy_sum + (wide_t'(1) <<< (bnbw_pkg::T_SHIFT - 1)))
                   >>> bnbw_pkg::T_SHIFT, bnbw_pkg::BR_W);
      br   = sat_w(ecnt_w * dy_w - held_dy_sum, bnbw_pkg::BR_W);
      br   = sat_w(br - t_w, bnbw_pkg::BR_W);
      coef = scale_w * istd_w * icnt_w;
      has_out  = 1'b1;
      res.kind = KIND_DX;
      res.dx   = SW'(sat_w((coef * br + (wide_t'(1) <<< (bnbw_pkg::DX_SHIFT - 1)))
                           >>> bnbw_pkg::DX_SHIFT, SW));
    end
  endtask

  task automatic send_item(input logic req, input logic [SW-1:0] x, input logic [SW-1:0] dy,
                           input logic lst, input logic typed, input grad_out_t typed_out);
    int        gap;
    bit        has_out;
    grad_out_t pred;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= req;
    in_x_sample  <= x;
    in_dy_sample <= dy;
    in_last      <= lst;
    do @(posedge clk); while (busy);
    apply_bwd_sample(req, x, dy, lst, has_out, pred);
    if (typed) channel_grads_q.push_back(typed_out);
    else if (has_out) channel_grads_q.push_back(pred);
    total_items++;
    if (req == REQ_ACCUM) acc_items++;
    else grad_items++;
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= IDX_W'(idx);
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bnbw_pkg::REG_SCALE: cfg_scale = val[bnbw_pkg::SCALE_W-1:0];
      bnbw_pkg::REG_MEAN:  cfg_mean  = val[bnbw_pkg::MEAN_W-1:0];
      bnbw_pkg::REG_ISTD:  cfg_istd  = val[bnbw_pkg::ISTD_W-1:0];
      bnbw_pkg::REG_ICNT:  cfg_icnt  = val[bnbw_pkg::ICNT_W-1:0];
      bnbw_pkg::REG_ECNT:  cfg_ecnt  = val[bnbw_pkg::ECNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    start <= 1'b0;
    while (channel_grads_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    grad_out_t exp_out;
    if (rst_n && out_valid) begin
      if (channel_grads_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: kind=%0d dx=%0d bias=%0d scale=%0d",
                   out_kind, out_dx, out_grad_bias, out_grad_scale);
      end else begin
        exp_out = channel_grads_q.pop_front();
        if (out_kind !== exp_out.kind || out_dx !== exp_out.dx ||
            out_grad_bias !== exp_out.grad_bias || out_grad_scale !== exp_out.grad_scale) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch: expected kind=%0d dx=%0d bias=%0d scale=%0d",
                     exp_out.kind, exp_out.dx, exp_out.grad_bias, exp_out.grad_scale);
            $display("          got      kind=%0d dx=%0d bias=%0d scale=%0d",
                     out_kind, out_dx, out_grad_bias, out_grad_scale);
          end
        end
        if (out_kind === KIND_SUMS) sums_seen++;
        else dx_seen++;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int                             k, p, n, seq_len, phase_start;
    logic [bnbw_pkg::SCALE_W-1:0]   scale_v;
    logic [bnbw_pkg::MEAN_W-1:0]    mean_v;
    logic [bnbw_pkg::ISTD_W-1:0]    istd_v;
    logic [bnbw_pkg::ICNT_W-1:0]    icnt_v;
    logic [bnbw_pkg::ECNT_W-1:0]    ecnt_v;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_req_type  <= 1'b0;
    in_x_sample  <= '0;
    in_dy_sample <= '0;
    in_last      <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++)
      send_item(dir_rows[k].req, dir_rows[k].x, dir_rows[k].dy, dir_rows[k].lst,
                dir_rows[k].typed, dir_rows[k].result);

    p = 0;
    while (total_items < ITEM_TARGET) begin
      case (p)
        0: begin
          scale_v = 16'h7FFF; mean_v = 16'h8000; istd_v = 16'hFFFF;
          icnt_v  = 24'hFFFFFF; ecnt_v = 21'h100000;
        end
        1: begin
          scale_v = 16'h8000; mean_v = 16'h7FFF; istd_v = 16'h0000;
          icnt_v  = 24'h000000; ecnt_v = 21'h000000;
        end
        2: begin
          scale_v = 16'($urandom); mean_v = 16'($urandom); istd_v = 16'($urandom);
          icnt_v  = 24'($urandom); ecnt_v = 21'h1FFFFF;
        end
        default: begin
          if (p % 2 == 1) begin
            n       = $urandom_range(1, 16);
            ecnt_v  = 21'(n);
            icnt_v  = (n == 1) ? 24'hFFFFFF : 24'((1 << 24) / n);
            scale_v = 16'($urandom_range(2048, 8192));
            mean_v  = 16'($urandom_range(0, 2047)) - 16'd1024;
            istd_v  = 16'($urandom_range(128, 1024));
          end else begin
            scale_v = 16'($urandom); mean_v = 16'($urandom); istd_v = 16'($urandom);
            icnt_v  = 24'($urandom); ecnt_v = 21'($urandom_range(1, 1 << 20));
          end
        end
      endcase
      settle();
      write_reg(bnbw_pkg::REG_SCALE, {8'($urandom), scale_v});
      write_reg(bnbw_pkg::REG_MEAN,  {8'($urandom), mean_v});
      write_reg(bnbw_pkg::REG_ISTD,  {8'($urandom), istd_v});
      write_reg(bnbw_pkg::REG_ICNT,  icnt_v);
      write_reg(bnbw_pkg::REG_ECNT,  {3'($urandom), ecnt_v});
      if (p == 1)
        for (k = int'(bnbw_pkg::REG_ECNT) + 1; k <= CFG_IDX_MAX; k++)
          write_reg(k, 24'($urandom));
      cfg_we <= 1'b0;
      settings_run++;
      phase_start = total_items;

      // drive the scale sum into saturation in both directions
      if (p == 0)
        for (n = 0; n < 2; n++) begin
          burst_mode = (n == 0);
          for (k = 0; k < SAT_LEN; k++)
            send_item(REQ_ACCUM, 16'h7FFF, n == 0 ? 16'h7FFF : 16'h8000,
                      1'(k == SAT_LEN - 1), 1'b0, '0);
          repeat (4) send_item(REQ_GRAD, rand_sample(), rand_sample(), 1'b0, 1'b0, '0);
        end

      while (total_items - phase_start < PHASE_ITEMS) begin
        burst_mode = ($urandom_range(0, 3) == 0);
        seq_len    = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          7: repeat (seq_len)
               send_item(1'($urandom), rand_sample(), rand_sample(), 1'($urandom), 1'b0, '0);
          8: begin
            repeat (seq_len)
              send_item(REQ_ACCUM, rand_sample(), rand_sample(), 1'b0, 1'b0, '0);
            repeat ($urandom_range(1, 4))
              send_item(REQ_GRAD, rand_sample(), rand_sample(), 1'($urandom), 1'b0, '0);
            send_item(REQ_ACCUM, rand_sample(), rand_sample(), 1'b1, 1'b0, '0);
          end
          9: repeat (seq_len)
               send_item(REQ_GRAD, rand_sample(), rand_sample(), 1'($urandom), 1'b0, '0);
          default: begin
            for (k = 0; k < seq_len; k++)
              send_item(REQ_ACCUM, rand_sample(), rand_sample(), 1'(k == seq_len - 1),
                        1'b0, '0);
            repeat ($urandom_range(1, seq_len + 2))
              send_item(REQ_GRAD, rand_sample(), rand_sample(), 1'($urandom), 1'b0, '0);
          end
        endcase
      end
      p++;
    end

    settle();
    $display("Covered %0d items (%0d accumulate, %0d gradient) under %0d register settings",
             total_items, acc_items, grad_items, settings_run);
    $display("Checked %0d channel-sum and %0d dx results in %0d cycles, %0d mismatches",
             sums_seen, dx_seen, cycle_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
